>>> rtl/ffha_pkg.sv
// Shared types, codes and constants of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

  // Fixed widths of addresses, sizes and the register port
  localparam int ADDR_W  = 32;
  localparam int PADDR_W = 3;

  // Register indexes on the configuration port
  localparam logic REG_HEAP_LIMIT = 1'b0;

  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'd1048576;

  // Operation codes of a request
  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_REALLOC = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Datapath actions of one microcode step
  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_CLAIM,
    OP_FREE_OLD,
    OP_RES_ADDR,
    OP_SET_NULL,
    OP_SET_NOT_FOUND,
    OP_SET_PEND
  } op_t;

  // Jump conditions of one microcode step
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_HIT,
    C_ZERO_SIZE,
    C_ZERO_ADDR,
    C_ZERO_ADDR_SIZE,
    C_OLD_FITS,
    C_NO_PEND
  } cond_t;

  // Microcode step addresses; fall-through goes to the next member
  typedef enum logic [4:0] {
    S_IDLE,
    S_A0,
    S_A1,
    S_A2,
    S_A_CLAIM,
    S_A3,
    S_A_FREE,
    S_NULL,
    S_F0,
    S_F1,
    S_F2,
    S_F3,
    S_R0,
    S_R1,
    S_R2,
    S_R3,
    S_R4,
    S_R5,
    S_FIN
  } upc_t;

  // One control word of the microprogram
  typedef struct packed {
    logic  scan_clr;
    logic  scan_en;
    logic  scan_fit;
    logic  loop;
    logic  fin;
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  // Status flags returned by the datapath
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic zero_size;
    logic zero_addr;
    logic old_fits;
    logic free_pend;
  } flags_t;

  // One block table entry
  typedef struct packed {
    logic              is_free;
    logic [ADDR_W-1:0] blk_size;
    logic [ADDR_W-1:0] blk_start;
  } entry_t;

endpackage

>>> rtl/ffha_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps
module ffha_seq
  import ffha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] mode,
  input  flags_t     flags,
  output ctrl_t      ctrl,
  output logic       busy
);

  upc_t upc;
  upc_t upc_next;
  logic cond_true;

  assign busy = (upc != S_IDLE);

  // Control ROM: one word per step
  always_comb begin
    ctrl        = '0;
    ctrl.op     = OP_NONE;
    ctrl.cond   = C_NONE;
    ctrl.target = S_IDLE;
    case (upc)
      S_IDLE: begin
      end
      S_A0: begin
        ctrl.scan_clr = 1'b1;
        ctrl.cond     = C_ZERO_SIZE;
        ctrl.target   = S_NULL;
      end
      S_A1: begin
        ctrl.scan_en  = 1'b1;
        ctrl.scan_fit = 1'b1;
        ctrl.loop     = 1'b1;
        ctrl.cond     = C_HIT;
        ctrl.target   = S_A_CLAIM;
      end
      S_A2: begin
        ctrl.op     = OP_APPEND;
        ctrl.cond   = C_ALWAYS;
        ctrl.target = S_A3;
      end
      S_A_CLAIM: begin
        ctrl.op = OP_CLAIM;
      end
      S_A3: begin
        ctrl.cond   = C_NO_PEND;
        ctrl.target = S_FIN;
      end
      S_A_FREE: begin
        ctrl.op   = OP_FREE_OLD;
        ctrl.fin  = 1'b1;
        ctrl.cond = C_ALWAYS;
      end
      S_NULL: begin
        ctrl.op   = OP_SET_NULL;
        ctrl.fin  = 1'b1;
        ctrl.cond = C_ALWAYS;
      end
      S_F0: begin
        ctrl.scan_clr = 1'b1;
        ctrl.cond     = C_ZERO_ADDR;
        ctrl.target   = S_FIN;
      end
      S_F1: begin
        ctrl.scan_en = 1'b1;
        ctrl.loop    = 1'b1;
        ctrl.cond    = C_HIT;
        ctrl.target  = S_F3;
      end
      S_F2: begin
        ctrl.op   = OP_SET_NOT_FOUND;
        ctrl.fin  = 1'b1;
        ctrl.cond = C_ALWAYS;
      end
      S_F3: begin
        ctrl.op   = OP_FREE_OLD;
        ctrl.fin  = 1'b1;
        ctrl.cond = C_ALWAYS;
      end
      S_R0: begin
        ctrl.scan_clr = 1'b1;
        ctrl.cond     = C_ZERO_ADDR_SIZE;
        ctrl.target   = S_A0;
      end
      S_R1: begin
        ctrl.scan_en = 1'b1;
        ctrl.loop    = 1'b1;
        ctrl.cond    = C_HIT;
        ctrl.target  = S_R3;
      end
      S_R2: begin
        ctrl.op   = OP_SET_NOT_FOUND;
        ctrl.fin  = 1'b1;
        ctrl.cond = C_ALWAYS;
      end
      S_R3: begin
        ctrl.cond   = C_OLD_FITS;
        ctrl.target = S_R5;
      end
      S_R4: begin
        ctrl.op       = OP_SET_PEND;
        ctrl.scan_clr = 1'b1;
        ctrl.cond     = C_ALWAYS;
        ctrl.target   = S_A1;
      end
      S_R5: begin
        ctrl.op   = OP_RES_ADDR;
        ctrl.fin  = 1'b1;
        ctrl.cond = C_ALWAYS;
      end
      S_FIN: begin
        ctrl.fin  = 1'b1;
        ctrl.cond = C_ALWAYS;
      end
      default: begin
        ctrl.cond = C_ALWAYS;
      end
    endcase
  end

  // Next step: dispatch on mode, jump, hold in a scan loop, or advance
  always_comb begin
    case (ctrl.cond)
      C_NONE:           cond_true = 1'b0;
      C_ALWAYS:         cond_true = 1'b1;
      C_HIT:            cond_true = flags.hit;
      C_ZERO_SIZE:      cond_true = flags.zero_size;
      C_ZERO_ADDR:      cond_true = flags.zero_addr;
      C_ZERO_ADDR_SIZE: cond_true = flags.zero_addr || flags.zero_size;
      C_OLD_FITS:       cond_true = flags.old_fits;
      C_NO_PEND:        cond_true = !flags.free_pend;
      default:          cond_true = 1'b0;
    endcase

    upc_next = upc;
    if (upc == S_IDLE) begin
      if (start) begin
        case (mode_t'(mode))
          MODE_ALLOC:   upc_next = S_A0;
          MODE_FREE:    upc_next = S_F0;
          MODE_REALLOC: upc_next = S_R0;
          default:      upc_next = S_FIN;
        endcase
      end
    end else if (cond_true) begin
      upc_next = ctrl.target;
    end else if (!(ctrl.loop && !flags.scan_done)) begin
      upc_next = upc_t'(upc + 5'd1);
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");

  a_fin_returns_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.fin |=> (upc == S_IDLE))
    else $error("final step did not return to idle");

endmodule

>>> rtl/ffha_dp.sv
// Datapath: block table memory, scan pointer, break, count and result registers.
`timescale 1ns / 1ps
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [ADDR_W-1:0] request_size,
  input  logic [ADDR_W-1:0] payload_addr,
  input  logic [ADDR_W-1:0] heap_limit,
  input  ctrl_t             ctrl,
  output flags_t            flags,
  output logic              done,
  output logic [ADDR_W-1:0] result_addr,
  output logic [1:0]        status,
  output logic              reused
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);

  entry_t            mem [MAX_BLOCKS];
  entry_t            rd_ent;
  logic [IW-1:0]     rd_idx;
  logic              rd_vld;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     entry_count;
  logic [ADDR_W-1:0] heap_break;
  logic [ADDR_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W:0]   total_r;
  logic [IW-1:0]     old_idx;
  logic [ADDR_W-1:0] old_start;
  logic [ADDR_W-1:0] old_size;
  logic [IW-1:0]     fit_idx;
  logic [ADDR_W-1:0] fit_start;
  logic [ADDR_W-1:0] fit_size;
  logic              pend;

  logic [ADDR_W-1:0] rd_payload;
  logic              find_match;
  logic              fit_match;
  logic              hit;
  logic              issue;
  logic [ADDR_W+1:0] grow_sum;
  logic              room;
  logic [ADDR_W+1:0] old_end;
  logic              old_last;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;

  // Compare the entry read last cycle against the request
  assign rd_payload = rd_ent.blk_start + HDR;
  assign find_match = (rd_payload == addr_r);
  assign fit_match  = rd_ent.is_free && (rd_ent.blk_size >= size_r);
  assign hit        = rd_vld && (ctrl.scan_fit ? fit_match : find_match);
  assign issue      = ctrl.scan_en && (ptr < entry_count);

  // Room check for growth at the break
  assign grow_sum = {2'b00, heap_break} + {1'b0, total_r};
  assign room     = (entry_count < CW'(MAX_BLOCKS)) && (grow_sum <= {2'b00, heap_limit});

  // Old block is the last one and ends at the break
  assign old_end  = {2'b00, old_start} + {2'b00, HDR} + {2'b00, old_size};
  assign old_last = ((CW'(old_idx) + CW'(1)) == entry_count) && (old_end == {2'b00, heap_break});

  assign flags.hit       = hit;
  assign flags.scan_done = !rd_vld && (ptr >= entry_count);
  assign flags.zero_size = (size_r == '0);
  assign flags.zero_addr = (addr_r == '0);
  assign flags.old_fits  = (old_size >= size_r);
  assign flags.free_pend = pend && (status == ST_OK);

  // Table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = old_idx;
    wr_data = '{is_free: 1'b1, blk_size: old_size, blk_start: old_start};
    case (ctrl.op)
      OP_APPEND: begin
        wr_en   = room;
        wr_addr = entry_count[IW-1:0];
        wr_data = '{is_free: 1'b0, blk_size: size_r, blk_start: heap_break};
      end
      OP_CLAIM: begin
        wr_en   = 1'b1;
        wr_addr = fit_idx;
        wr_data = '{is_free: 1'b0, blk_size: fit_size, blk_start: fit_start};
      end
      OP_FREE_OLD: begin
        wr_en = !old_last;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_ent <= mem[ptr[IW-1:0]];
    end
  end

  // Request operands, read index and captured hits
  always_ff @(posedge clk) begin
    if (accept) begin
      size_r  <= request_size;
      addr_r  <= payload_addr;
      total_r <= {1'b0, request_size} + {1'b0, HDR};
    end
    if (issue) begin
      rd_idx <= ptr[IW-1:0];
    end
    if (ctrl.scan_en && hit) begin
      if (ctrl.scan_fit) begin
        fit_idx   <= rd_idx;
        fit_start <= rd_ent.blk_start;
        fit_size  <= rd_ent.blk_size;
      end else begin
        old_idx   <= rd_idx;
        old_start <= rd_ent.blk_start;
        old_size  <= rd_ent.blk_size;
      end
    end
  end

  // Control state, heap break and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      heap_break  <= '0;
      ptr         <= '0;
      rd_vld      <= 1'b0;
      pend        <= 1'b0;
      done        <= 1'b0;
      result_addr <= '0;
      status      <= ST_OK;
      reused      <= 1'b0;
    end else begin
      done <= ctrl.fin;
      if (accept) begin
        result_addr <= '0;
        status      <= ST_OK;
        reused      <= 1'b0;
        pend        <= 1'b0;
      end
      // Advance the scan one entry a cycle while scan_en is set and entries remain
      if (ctrl.scan_clr) begin
        ptr    <= '0;
        rd_vld <= 1'b0;
      end else if (ctrl.scan_en) begin
        rd_vld <= issue;
        if (issue) begin
          ptr <= ptr + CW'(1);
        end
      end
      case (ctrl.op)
        OP_APPEND: begin
          if (room) begin
            entry_count <= entry_count + CW'(1);
            heap_break  <= grow_sum[ADDR_W-1:0];
            result_addr <= heap_break + HDR;
          end else begin
            status <= ST_NULL;
          end
        end
        OP_CLAIM: begin
          result_addr <= fit_start + HDR;
          reused      <= 1'b1;
        end
        OP_FREE_OLD: begin
          if (old_last) begin
            entry_count <= entry_count - CW'(1);
            heap_break  <= old_start;
          end
        end
        OP_RES_ADDR: begin
          result_addr <= addr_r;
          reused      <= 1'b1;
        end
        OP_SET_NULL:      status <= ST_NULL;
        OP_SET_NOT_FOUND: status <= ST_NOT_FOUND;
        OP_SET_PEND:      pend   <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  a_empty_heap_no_break: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0) |-> (heap_break == '0))
    else $error("empty table with a non-zero break");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_BLOCKS))
    else $error("entry count beyond table depth");

endmodule

>>> rtl/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: register port and unit wiring.
//
// Usage: raise start with mode, request_size and payload_addr; the request
// is taken at a rising edge where start is high and busy is low. busy stays
// high until the result goes out. The result (result_addr, status, reused)
// is shown for one cycle with done high; the receiver cannot stall it and
// the next request may be taken in that same cycle.
// Each table scan reads one entry per cycle from the block memory and stops
// at a hit or after the last of the N blocks in the table. Reallocate runs
// an address lookup scan and, when the old block is too small, a first-fit
// scan after it; a zero address free skips the scan. One request is in
// flight at a time. heap_limit is written over the APB port at byte address
// 0; the user must write it only while idle, as the block does not enforce
// that. Reset empties the table, clears the break and sets heap_limit to
// 1 MiB; no clearing pass runs, and a request may be taken on the next cycle.
`timescale 1ns / 1ps
module first_fit_heap_allocator_top
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [ADDR_W-1:0]  request_size,
  input  logic [ADDR_W-1:0]  payload_addr,
  output logic               done,
  output logic [ADDR_W-1:0]  result_addr,
  output logic [1:0]         status,
  output logic               reused,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic              accept;
  logic              cfg_wr;
  logic [ADDR_W-1:0] heap_limit;
  ctrl_t             ctrl;
  flags_t            flags;

  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= HEAP_LIMIT_RESET;
    end else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_HEAP_LIMIT)) begin
      heap_limit <= pwdata;
    end
  end

  // Read back
  always_comb begin
    if (paddr[PADDR_W-1:2] == REG_HEAP_LIMIT) begin
      prdata = heap_limit;
    end else begin
      prdata = '0;
    end
  end

  ffha_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  ffha_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .request_size (request_size),
    .payload_addr (payload_addr),
    .heap_limit   (heap_limit),
    .ctrl         (ctrl),
    .flags        (flags),
    .done         (done),
    .result_addr  (result_addr),
    .status       (status),
    .reused       (reused)
  );

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_no_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !done)
    else $error("result strobe straight after a request was taken");

endmodule
